/* hdl/blr_pkg.sv */
`timescale 1ns / 1ps
// Shared types, command codes and octant codes of the line rasterizer.
// No dependencies; blr_front, blr_back and the top level import this package.
package blr_pkg;

  // Command codes carried in the func field.
  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_STEP  = 1'b1;

  // Octant codes, octants one to eight.
  localparam logic [2:0] OCT_0 = 3'd0;
  localparam logic [2:0] OCT_1 = 3'd1;
  localparam logic [2:0] OCT_2 = 3'd2;
  localparam logic [2:0] OCT_3 = 3'd3;
  localparam logic [2:0] OCT_4 = 3'd4;
  localparam logic [2:0] OCT_5 = 3'd5;
  localparam logic [2:0] OCT_6 = 3'd6;
  localparam logic [2:0] OCT_7 = 3'd7;

  // Walk controls of one octant.
  typedef struct packed {
    logic x_major;       // x is the major axis
    logic x_dec;         // x moves toward smaller values
    logic y_dec;         // y moves toward smaller values
    logic straight_neg;  // straight move when the decision is negative
  } oct_ctrl_t;

  function automatic oct_ctrl_t oct_ctrl(input logic [2:0] oct);
    oct_ctrl_t c;
    case (oct)
      OCT_0:   c = '{x_major: 1'b1, x_dec: 1'b0, y_dec: 1'b0, straight_neg: 1'b1};
      OCT_1:   c = '{x_major: 1'b0, x_dec: 1'b0, y_dec: 1'b0, straight_neg: 1'b0};
      OCT_2:   c = '{x_major: 1'b0, x_dec: 1'b1, y_dec: 1'b0, straight_neg: 1'b1};
      OCT_3:   c = '{x_major: 1'b1, x_dec: 1'b1, y_dec: 1'b0, straight_neg: 1'b0};
      OCT_4:   c = '{x_major: 1'b1, x_dec: 1'b1, y_dec: 1'b1, straight_neg: 1'b1};
      OCT_5:   c = '{x_major: 1'b0, x_dec: 1'b1, y_dec: 1'b1, straight_neg: 1'b0};
      OCT_6:   c = '{x_major: 1'b0, x_dec: 1'b0, y_dec: 1'b1, straight_neg: 1'b1};
      default: c = '{x_major: 1'b1, x_dec: 1'b0, y_dec: 1'b1, straight_neg: 1'b0};
    endcase
    return c;
  endfunction

endpackage

/* hdl/blr_front.sv */
`timescale 1ns / 1ps
// Command front end: accepts commands, picks the octant of a new line and
// computes the decision variable and its increments. Depends on blr_pkg.
module blr_front import blr_pkg::*; #(
  parameter int COORD_BITS = 9
) (
  input  logic                                  cmd_valid,
  output logic                                  cmd_stall,
  input  logic                                  func,
  input  logic [COORD_BITS-1:0]                 start_x,
  input  logic [COORD_BITS-1:0]                 start_y,
  input  logic [COORD_BITS-1:0]                 end_x,
  input  logic [COORD_BITS-1:0]                 end_y,
  input  logic                                  queue_full,
  output logic                                  push,
  output logic [7*COORD_BITS+16-1:0]            push_data
);

  localparam int DW = COORD_BITS + 4;

  logic signed [DW-1:0] dx, dy, ax, ay, dx2, dy2;
  logic signed [DW-1:0] dec, inc_s, inc_d;
  logic [2:0]           oct;

  assign cmd_stall = queue_full;
  assign push      = cmd_valid && !queue_full;

  always_comb begin
    dx  = $signed({4'b0000, end_x}) - $signed({4'b0000, start_x});
    dy  = $signed({4'b0000, end_y}) - $signed({4'b0000, start_y});
    ax  = dx[DW-1] ? -dx : dx;
    ay  = dy[DW-1] ? -dy : dy;
    dx2 = dx <<< 1;
    dy2 = dy <<< 1;

    // Tie rules differ per quadrant; the order of the tests matters.
    if (!dy[DW-1] && !dx[DW-1]) begin
      oct = (ax >= ay) ? OCT_0 : OCT_1;
    end else if (!dx[DW-1]) begin
      oct = (ax > ay) ? OCT_7 : OCT_6;
    end else if (!dy[DW-1]) begin
      oct = (ax < ay) ? OCT_2 : OCT_3;
    end else begin
      oct = (ax > ay) ? OCT_4 : OCT_5;
    end

    case (oct)
      OCT_0: begin
        dec = dy2 - dx;  inc_s = dy2;  inc_d = dy2 - dx2;
      end
      OCT_1: begin
        dec = dy - dx2;  inc_s = -dx2; inc_d = dy2 - dx2;
      end
      OCT_2: begin
        dec = -dy - dx2; inc_s = -dx2; inc_d = -dy2 - dx2;
      end
      OCT_3: begin
        dec = -dy2 - dx; inc_s = -dy2; inc_d = -dy2 - dx2;
      end
      OCT_4: begin
        dec = -dy2 + dx; inc_s = -dy2; inc_d = -dy2 + dx2;
      end
      OCT_5: begin
        dec = -dy + dx2; inc_s = dx2;  inc_d = -dy2 + dx2;
      end
      OCT_6: begin
        dec = dy + dx2;  inc_s = dx2;  inc_d = dy2 + dx2;
      end
      default: begin
        dec = dy2 + dx;  inc_s = dy2;  inc_d = dy2 + dx2;
      end
    endcase
  end

  assign push_data = {func, start_x, start_y, end_x, end_y, oct, dec, inc_s, inc_d};

endmodule

/* hdl/blr_queue.sv */
`timescale 1ns / 1ps
// Two-entry queue between the command front end and the walk engine.
// Generic in width; no package dependencies.
module blr_queue #(
  parameter int WIDTH = 79
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* hdl/blr_back.sv */
`timescale 1ns / 1ps
// Walk engine: holds the line in progress, takes queued commands and emits
// one pixel per step of an open line through a registered output. Depends on blr_pkg.
module blr_back import blr_pkg::*; #(
  parameter int COORD_BITS = 9
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_not_empty,
  input  logic [7*COORD_BITS+16-1:0]    q_data,
  output logic                          pop,
  output logic                          pix_valid,
  input  logic                          pix_stall,
  output logic [COORD_BITS-1:0]         pixel_x,
  output logic [COORD_BITS-1:0]         pixel_y,
  output logic                          last
);

  localparam int DW = COORD_BITS + 4;
  localparam int PW = COORD_BITS + 2;
  localparam logic signed [PW-1:0] ONE = PW'(1);

  logic                  e_func;
  logic [COORD_BITS-1:0] e_x0, e_y0, e_x1, e_y1;
  logic [2:0]            e_oct;
  logic signed [DW-1:0]  e_dec, e_inc_s, e_inc_d;

  // Line state.
  logic                  busy;
  logic signed [PW-1:0]  cur_x, cur_y;
  logic [COORD_BITS-1:0] target_x, target_y;
  logic signed [DW-1:0]  decision, inc_straight, inc_diagonal;
  logic [2:0]            octant;

  logic signed [PW-1:0]  cur_x_next, cur_y_next, tx, ty;
  logic signed [DW-1:0]  decision_next;
  oct_ctrl_t             ctrl;
  logic                  straight, out_free, do_step, do_start, at_end, okx, oky;

  assign {e_func, e_x0, e_y0, e_x1, e_y1, e_oct, e_dec, e_inc_s, e_inc_d} = q_data;

  assign out_free = !pix_valid || !pix_stall;
  // A start or an idle step never needs the output register.
  assign pop      = q_not_empty && ((e_func == FUNC_START) || !busy || out_free);
  assign do_start = pop && (e_func == FUNC_START);
  assign do_step  = pop && (e_func == FUNC_STEP) && busy;

  always_comb begin
    ctrl     = oct_ctrl(octant);
    straight = ctrl.straight_neg ? (decision < 0) : (decision > 0);
    decision_next = decision + (straight ? inc_straight : inc_diagonal);
    cur_x_next = cur_x;
    cur_y_next = cur_y;
    if (ctrl.x_major || !straight) begin
      cur_x_next = ctrl.x_dec ? cur_x - ONE : cur_x + ONE;
    end
    if (!ctrl.x_major || !straight) begin
      cur_y_next = ctrl.y_dec ? cur_y - ONE : cur_y + ONE;
    end
    tx     = $signed({2'b00, target_x});
    ty     = $signed({2'b00, target_y});
    okx    = ctrl.x_dec ? (cur_x_next >= tx) : (cur_x_next <= tx);
    oky    = ctrl.y_dec ? (cur_y_next >= ty) : (cur_y_next <= ty);
    at_end = !(okx && oky);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      pix_valid <= 1'b0;
    end else begin
      if (do_start) begin
        busy <= 1'b1;
      end else if (do_step && at_end) begin
        busy <= 1'b0;
      end
      if (do_step) begin
        pix_valid <= 1'b1;
      end else if (!pix_stall) begin
        pix_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_start) begin
      cur_x        <= $signed({2'b00, e_x0});
      cur_y        <= $signed({2'b00, e_y0});
      target_x     <= e_x1;
      target_y     <= e_y1;
      decision     <= e_dec;
      inc_straight <= e_inc_s;
      inc_diagonal <= e_inc_d;
      octant       <= e_oct;
    end else if (do_step) begin
      cur_x    <= cur_x_next;
      cur_y    <= cur_y_next;
      decision <= decision_next;
    end
    if (do_step) begin
      pixel_x <= cur_x[COORD_BITS-1:0];
      pixel_y <= cur_y[COORD_BITS-1:0];
      last    <= at_end;
    end
  end

endmodule

/* hdl/bresenham_line_rasterizer.sv */
`timescale 1ns / 1ps
// Eight-octant Bresenham line rasterizer. A start command (func = 0) loads the
// endpoints and gives no pixel; each step command (func = 1) gives the current
// pixel, with last set on the final one, and a step while no line is open
// gives nothing. The block takes one command per clock cycle while the output
// keeps up, and a step command's pixel passes through the queue and then the
// registered output of the walk engine; that rate is set by the walk engine
// updating its decision variable as it emits each pixel. A two-entry queue
// separates command intake from the walk engine.
// Depends on blr_pkg, blr_front, blr_queue and blr_back.
module bresenham_line_rasterizer import blr_pkg::*; #(
  parameter int COORD_BITS = 9
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  output logic                  cmd_stall,
  input  logic                  func,
  input  logic [COORD_BITS-1:0] start_x,
  input  logic [COORD_BITS-1:0] start_y,
  input  logic [COORD_BITS-1:0] end_x,
  input  logic [COORD_BITS-1:0] end_y,
  output logic                  pix_valid,
  input  logic                  pix_stall,
  output logic [COORD_BITS-1:0] pixel_x,
  output logic [COORD_BITS-1:0] pixel_y,
  output logic                  last
);

  localparam int EW = 7 * COORD_BITS + 16;

  logic          push, pop, queue_full, q_not_empty;
  logic [EW-1:0] push_data, q_data;

  blr_front #(.COORD_BITS(COORD_BITS)) u_front (
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .func      (func),
    .start_x   (start_x),
    .start_y   (start_y),
    .end_x     (end_x),
    .end_y     (end_y),
    .queue_full(queue_full),
    .push      (push),
    .push_data (push_data)
  );

  blr_queue #(.WIDTH(EW)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_data),
    .full     (queue_full),
    .pop      (pop),
    .not_empty(q_not_empty),
    .pop_data (q_data)
  );

  blr_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_not_empty(q_not_empty),
    .q_data     (q_data),
    .pop        (pop),
    .pix_valid  (pix_valid),
    .pix_stall  (pix_stall),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .last       (last)
  );

endmodule

/* hdl/blr_checker.sv */
`timescale 1ns / 1ps
// Port-level checks of the line rasterizer, bound to its top level.
// Depends on bresenham_line_rasterizer.
module blr_checker #(
  parameter int COORD_BITS = 9
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  cmd_valid,
  input logic                  cmd_stall,
  input logic                  pix_valid,
  input logic                  pix_stall,
  input logic [COORD_BITS-1:0] pixel_x,
  input logic [COORD_BITS-1:0] pixel_y,
  input logic                  last
);

  logic cmd_xfer;
  assign cmd_xfer = cmd_valid && !cmd_stall;

  // Reset empties the queue and the output register.
  a_reset_clear: assert property (@(posedge clk) rst |=> !cmd_stall && !pix_valid)
    else $error("queue or output not empty after reset");

  // A stalled pixel holds its value.
  a_pix_hold: assert property (@(posedge clk) disable iff (rst)
    pix_valid && pix_stall |=> pix_valid && $stable(pixel_x) && $stable(pixel_y)
      && $stable(last))
    else $error("stalled pixel changed");

  // With no command transfer and no output stall the block drains the queue and
  // the output register; nothing is invented from an empty queue.
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (!cmd_xfer && !pix_stall) ##1 (!cmd_xfer && !pix_stall)
      ##1 (!cmd_xfer && !pix_stall) |=> !pix_valid)
    else $error("pixel appeared without a pending command");

endmodule

bind bresenham_line_rasterizer blr_checker #(.COORD_BITS(COORD_BITS)) u_blr_checker (
  .clk      (clk),
  .rst      (rst),
  .cmd_valid(cmd_valid),
  .cmd_stall(cmd_stall),
  .pix_valid(pix_valid),
  .pix_stall(pix_stall),
  .pixel_x  (pixel_x),
  .pixel_y  (pixel_y),
  .last     (last)
);
